// ----- hdl/bfa_pkg.sv -----
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and codes of the best-fit block allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FIT  = 2'd1,
    ST_BAD     = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

endpackage

// ----- hdl/best_fit_block_allocator.sv -----
// ----------------------------------------------------------------------------
// best_fit_block_allocator
// Best-fit heap allocator over whole blocks with coalescing on free.
// ----------------------------------------------------------------------------
// Usage: drive in_command, in_block_count and in_start_block and pulse start
// while busy is low; the request transfers at that edge. busy stays high until
// the answer is shown. out_result_block and out_status are valid for exactly
// one cycle with out_valid high; the receiver cannot stall.
// Operation: every scan steps over the fragment table or the held table one
// entry a cycle. An allocate runs a search, a held slot scan and a remove
// shift, then, if the fragment is split, an insert position scan and an
// insert shift; a free runs a held lookup, a neighbor scan, up to two removes
// and one insert. A zero-count allocate is refused without a scan; other
// errors answer after the scan that finds them.
// Reset: rst_n low for one edge leaves one free fragment covering blocks 1
// to HEAP_BLOCKS-1 and an empty held table. Block 0 is never handed out.
// Only one request is in flight at a time.
// ----------------------------------------------------------------------------
module best_fit_block_allocator
  import bfa_pkg::*;
#(
  parameter int HEAP_BLOCKS   = 4096,
  parameter int TABLE_ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_command,
  input  logic [12:0] in_block_count,
  input  logic [11:0] in_start_block,
  output logic        out_valid,
  output logic [11:0] out_result_block,
  output logic [1:0]  out_status
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  // wide enough for the heap and for the full request and address fields
  localparam int AW = ($clog2(HEAP_BLOCKS + 1) > 13) ? $clog2(HEAP_BLOCKS + 1) : 13;

  typedef enum logic [3:0] {
    S_IDLE, S_A_SRCH, S_A_SLOT, S_A_TAKE, S_F_LOOK, S_F_GET, S_F_NBR, S_F_MRG,
    S_RM, S_INS_POS, S_INS_SH, S_INS_WR, S_DONE
  } state_t;

  logic [AW-1:0] fs_mem [TABLE_ENTRIES];
  logic [AW-1:0] fl_mem [TABLE_ENTRIES];
  logic [AW-1:0] hs_mem [TABLE_ENTRIES];
  logic [AW-1:0] hl_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] held_used_r;

  state_t        state_r;
  logic [CW-1:0] fcnt_r;
  logic [CW-1:0] k_r;
  logic [AW-1:0] cnt_r, addr_r, st_r, ln_r;
  logic [CW-1:0] pos_r, slot_r, left_r, right_r, rm2_r;
  logic          do_ins_r, rm2_v_r;
  logic [AW-1:0] ins_s_r, ins_l_r;
  logic [11:0]   res_r;
  status_t       stat_r;
  logic          ov_r;

  logic [IW-1:0] ki;
  logic [AW-1:0] fs_k, fl_k, hs_k;
  assign ki   = k_r[IW-1:0];
  assign fs_k = fs_mem[ki];
  assign fl_k = fl_mem[ki];
  assign hs_k = hs_mem[ki];

  logic [AW:0] fend_k;
  assign fend_k = {1'b0, fs_k} + {1'b0, fl_k};

  localparam logic [CW-1:0] NONE = CW'(TABLE_ENTRIES);

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = ov_r;
  assign out_result_block = res_r;
  assign out_status       = stat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fcnt_r      <= CW'(1);
      held_used_r <= '0;
      ov_r        <= 1'b0;
      fs_mem[0]   <= AW'(1);
      fl_mem[0]   <= AW'(HEAP_BLOCKS - 1);
    end else begin
      ov_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            cnt_r   <= AW'(in_block_count);
            addr_r  <= AW'(in_start_block);
            k_r     <= '0;
            left_r  <= NONE;
            right_r <= NONE;
            if (in_command == CMD_ALLOC) begin
              if (in_block_count == 13'd0) begin
                res_r <= '0; stat_r <= ST_BAD; state_r <= S_DONE;
              end else begin
                state_r <= S_A_SRCH;
              end
            end else begin
              state_r <= S_F_LOOK;
            end
          end
        end
        S_A_SRCH: begin
          if (k_r >= fcnt_r) begin
            res_r <= '0; stat_r <= ST_NO_FIT; state_r <= S_DONE;
          end else if (fl_k >= cnt_r) begin
            pos_r <= k_r; st_r <= fs_k; ln_r <= fl_k;
            k_r <= '0; state_r <= S_A_SLOT;
          end else begin
            k_r <= k_r + CW'(1);
          end
        end
        S_A_SLOT: begin
          if (k_r == NONE) begin
            res_r <= '0; stat_r <= ST_FULL; state_r <= S_DONE;
          end else if (!held_used_r[ki]) begin
            slot_r <= k_r; state_r <= S_A_TAKE;
          end else begin
            k_r <= k_r + CW'(1);
          end
        end
        S_A_TAKE: begin
          hs_mem[slot_r[IW-1:0]]      <= st_r;
          hl_mem[slot_r[IW-1:0]]      <= cnt_r;
          held_used_r[slot_r[IW-1:0]] <= 1'b1;
          res_r    <= st_r[11:0];
          stat_r   <= ST_OK;
          do_ins_r <= (ln_r > cnt_r);
          ins_s_r  <= st_r + cnt_r;
          ins_l_r  <= ln_r - cnt_r;
          rm2_v_r  <= 1'b0;
          k_r      <= pos_r;
          state_r  <= S_RM;
        end
        S_F_LOOK: begin
          if (k_r == NONE) begin
            res_r <= '0; stat_r <= ST_BAD; state_r <= S_DONE;
          end else if (held_used_r[ki] && hs_k == addr_r) begin
            slot_r <= k_r; state_r <= S_F_GET;
          end else begin
            k_r <= k_r + CW'(1);
          end
        end
        S_F_GET: begin
          st_r <= hs_mem[slot_r[IW-1:0]];
          ln_r <= hl_mem[slot_r[IW-1:0]];
          k_r <= '0; state_r <= S_F_NBR;
        end
        S_F_NBR: begin
          if (k_r >= fcnt_r) begin
            state_r <= S_F_MRG;
          end else begin
            if (left_r == NONE && fend_k == {1'b0, st_r})
              left_r <= k_r;
            else if (right_r == NONE && {1'b0, fs_k} == {1'b0, st_r} + {1'b0, ln_r})
              right_r <= k_r;
            k_r <= k_r + CW'(1);
          end
        end
        S_F_MRG: begin
          // one pass: fold neighbor lengths in while reading them by index
          if (left_r == NONE && right_r == NONE && fcnt_r >= NONE) begin
            res_r <= '0; stat_r <= ST_FULL; state_r <= S_DONE;
          end else begin
            held_used_r[slot_r[IW-1:0]] <= 1'b0;
            res_r    <= '0;
            stat_r   <= ST_OK;
            do_ins_r <= 1'b1;
            ins_s_r  <= (left_r != NONE) ? fs_mem[left_r[IW-1:0]] : st_r;
            ins_l_r  <= ln_r
                      + ((left_r != NONE) ? fl_mem[left_r[IW-1:0]] : '0)
                      + ((right_r != NONE) ? fl_mem[right_r[IW-1:0]] : '0);
            if (left_r != NONE && right_r != NONE) begin
              k_r     <= (left_r > right_r) ? left_r : right_r;
              rm2_r   <= (left_r > right_r) ? right_r : left_r;
              rm2_v_r <= 1'b1;
              state_r <= S_RM;
            end else if (left_r != NONE || right_r != NONE) begin
              k_r     <= (left_r != NONE) ? left_r : right_r;
              rm2_v_r <= 1'b0;
              state_r <= S_RM;
            end else begin
              k_r <= '0; state_r <= S_INS_POS;
            end
          end
        end
        S_RM: begin
          // shift entries down over the removed one, one per cycle
          if (k_r + CW'(1) < fcnt_r) begin
            fs_mem[ki] <= fs_mem[IW'(k_r + CW'(1))];
            fl_mem[ki] <= fl_mem[IW'(k_r + CW'(1))];
            k_r <= k_r + CW'(1);
          end else begin
            fcnt_r <= fcnt_r - CW'(1);
            if (rm2_v_r) begin
              rm2_v_r <= 1'b0; k_r <= rm2_r;
            end else if (do_ins_r) begin
              k_r <= '0; state_r <= S_INS_POS;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_INS_POS: begin
          if (fcnt_r >= NONE) begin
            state_r <= S_DONE;
          end else if (k_r < fcnt_r && fl_k < ins_l_r) begin
            k_r <= k_r + CW'(1);
          end else begin
            pos_r <= k_r; k_r <= fcnt_r; state_r <= S_INS_SH;
          end
        end
        S_INS_SH: begin
          if (k_r > pos_r) begin
            fs_mem[ki] <= fs_mem[IW'(k_r - CW'(1))];
            fl_mem[ki] <= fl_mem[IW'(k_r - CW'(1))];
            k_r <= k_r - CW'(1);
          end else begin
            state_r <= S_INS_WR;
          end
        end
        S_INS_WR: begin
          fs_mem[pos_r[IW-1:0]] <= ins_s_r;
          fl_mem[pos_r[IW-1:0]] <= ins_l_r;
          fcnt_r  <= fcnt_r + CW'(1);
          state_r <= S_DONE;
        end
        S_DONE: begin
          ov_r    <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
